[src/ket_pkg.sv]
// Shared types, constants and helpers for the keyed EMA level tracker.
package ket_pkg;

	localparam int unsigned TOPICS_DEF = 16;

	localparam logic [16:0] ONE_Q16        = 17'd65536;
	localparam logic [16:0] DEFAULT_WEIGHT = 17'd19661;
	localparam logic [16:0] TH_EXPERT      = 17'd9831;
	localparam logic [16:0] TH_ADVANCED    = 17'd22938;
	localparam logic [16:0] TH_INTERMEDIATE = 17'd39322;

	localparam logic CMD_OBSERVE  = 1'b0;
	localparam logic CMD_FEEDBACK = 1'b1;

	localparam logic [1:0] LEN_MAX     = 2'd3;
	localparam logic [1:0] TONE_MAX    = 2'd2;
	localparam logic [1:0] DET_MAX     = 2'd2;
	localparam logic [1:0] LEN_NORMAL  = 2'd2;
	localparam logic [1:0] TONE_NEUTRAL = 2'd1;
	localparam logic [1:0] DET_NEUTRAL = 2'd1;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_REJECT = 2'd1,
		STS_BAD_FB = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		LVL_UNKNOWN      = 3'd0,
		LVL_BEGINNER     = 3'd1,
		LVL_INTERMEDIATE = 3'd2,
		LVL_ADVANCED     = 3'd3,
		LVL_EXPERT       = 3'd4
	} level_t;

	typedef enum logic [2:0] {
		FB_TOO_LONG      = 3'd0,
		FB_TOO_SHORT     = 3'd1,
		FB_TOO_TECHNICAL = 3'd2,
		FB_TOO_SIMPLE    = 3'd3,
		FB_TOO_FORMAL    = 3'd4,
		FB_TOO_DIRECT    = 3'd5
	} fb_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_CHECK,
		ST_MUL,
		ST_UPDATE,
		ST_FEED,
		ST_REJECT
	} state_t;

	typedef struct packed {
		logic [63:0] key;
		logic [16:0] ema;
		logic [31:0] samples;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic [16:0] ema_value;
		level_t      level;
		logic [31:0] sample_count;
		logic        changed;
		logic [1:0]  length_style;
		logic [1:0]  tone_style;
		logic [1:0]  detail_style;
		logic [31:0] adapt_count;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic rd;
		logic idx_inc;
		logic set_new;
		logic set_hit;
		logic mul;
		logic finish_obs;
		logic finish_fb;
		logic finish_rej;
	} dp_cmd_t;

	typedef struct packed {
		logic is_feedback;
		logic key_zero;
		logic scan_end;
		logic table_full;
		logic key_hit;
		logic out_free;
	} dp_sts_t;

	function automatic level_t classify(input logic [16:0] ema);
		level_t lvl;
		if (ema < TH_EXPERT)
			lvl = LVL_EXPERT;
		else if (ema < TH_ADVANCED)
			lvl = LVL_ADVANCED;
		else if (ema < TH_INTERMEDIATE)
			lvl = LVL_INTERMEDIATE;
		else
			lvl = LVL_BEGINNER;
		return lvl;
	endfunction

endpackage

[src/ket_req_if.sv]
// Input word channel: observation or style feedback.
interface ket_req_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [63:0]        topic_key;
	logic signed [17:0] sample;
	logic [2:0]         feedback_kind;

	modport source (output valid, command, topic_key, sample, feedback_kind, input ready);
	modport sink (input valid, command, topic_key, sample, feedback_kind, output ready);
endinterface

[src/ket_rsp_if.sv]
// Result word channel.
interface ket_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [16:0] ema_value;
	logic [2:0]  level;
	logic [31:0] sample_count;
	logic        changed;
	logic [1:0]  length_style;
	logic [1:0]  tone_style;
	logic [1:0]  detail_style;
	logic [31:0] adapt_count;

	modport source (output valid, status, ema_value, level, sample_count, changed,
		length_style, tone_style, detail_style, adapt_count, input ready);
	modport sink (input valid, status, ema_value, level, sample_count, changed,
		length_style, tone_style, detail_style, adapt_count, output ready);
endinterface

[src/ket_cfg_if.sv]
// Configuration write channel for the blend weight.
interface ket_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] blend_weight;

	modport source (output valid, blend_weight, input ready);
	modport sink (input valid, blend_weight, output ready);
endinterface

[src/keyed_ema_level_tracker_unit.sv]
// Keyed EMA level tracker, top level. One result word per input word. A feedback word
// or an observation with an empty key goes from IDLE through DECODE to FEED or REJECT,
// where its result is registered once the result register is free. An observation
// scans the topic table through the single read port of the table memory, one SCAN
// and one CHECK state per entry examined, then blends in MUL and UPDATE: a key found in
// the table or a new key is blended and stored, and a new key against a full table is
// rejected. The next word is accepted in the cycle after a result is registered, while
// that result may still wait for the sink. The table starts empty after reset and needs
// no clearing pass.
module keyed_ema_level_tracker_unit #(
	parameter int unsigned TOPICS = ket_pkg::TOPICS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	ket_req_if.sink   req,
	ket_rsp_if.source rsp,
	ket_cfg_if.sink   cfg
);

	ket_pkg::dp_cmd_t cmd;
	ket_pkg::dp_sts_t sts;
	logic             req_ready;

	assign req.ready = req_ready;

	ket_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ket_dp #(
		.TOPICS (TOPICS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (req.command),
		.topic_key     (req.topic_key),
		.sample        (req.sample),
		.feedback_kind (req.feedback_kind),
		.cmd           (cmd),
		.sts           (sts),
		.cfg           (cfg),
		.rsp           (rsp)
	);

endmodule

[src/ket_ctrl.sv]
// Sequencer for the tracker: decode, table scan, blend and result hand-off.
module ket_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  ket_pkg::dp_sts_t sts,
	output ket_pkg::dp_cmd_t cmd
);

	ket_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ket_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ket_pkg::ST_IDLE: begin
				if (req_valid)
					state_d = ket_pkg::ST_DECODE;
			end
			ket_pkg::ST_DECODE: begin
				if (sts.is_feedback)
					state_d = ket_pkg::ST_FEED;
				else if (sts.key_zero)
					state_d = ket_pkg::ST_REJECT;
				else
					state_d = ket_pkg::ST_SCAN;
			end
			ket_pkg::ST_SCAN: begin
				if (!sts.scan_end)
					state_d = ket_pkg::ST_CHECK;
				else if (sts.table_full)
					state_d = ket_pkg::ST_REJECT;
				else
					state_d = ket_pkg::ST_MUL;
			end
			ket_pkg::ST_CHECK: begin
				if (sts.key_hit)
					state_d = ket_pkg::ST_MUL;
				else
					state_d = ket_pkg::ST_SCAN;
			end
			ket_pkg::ST_MUL: state_d = ket_pkg::ST_UPDATE;
			ket_pkg::ST_UPDATE, ket_pkg::ST_FEED, ket_pkg::ST_REJECT: begin
				if (sts.out_free)
					state_d = ket_pkg::ST_IDLE;
			end
			default: state_d = ket_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ket_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.capture = req_valid;
			end
			ket_pkg::ST_DECODE: ;
			ket_pkg::ST_SCAN: begin
				cmd.rd = !sts.scan_end;
				cmd.set_new = sts.scan_end && !sts.table_full;
			end
			ket_pkg::ST_CHECK: begin
				cmd.set_hit = sts.key_hit;
				cmd.idx_inc = !sts.key_hit;
			end
			ket_pkg::ST_MUL: cmd.mul = 1'b1;
			ket_pkg::ST_UPDATE: cmd.finish_obs = sts.out_free;
			ket_pkg::ST_FEED: cmd.finish_fb = sts.out_free;
			ket_pkg::ST_REJECT: cmd.finish_rej = sts.out_free;
			default: ;
		endcase
	end

endmodule

[src/ket_dp.sv]
// Datapath: topic table memory, EMA blend, style settings and result register.
module ket_dp #(
	parameter int unsigned TOPICS = ket_pkg::TOPICS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               command,
	input  logic [63:0]        topic_key,
	input  logic signed [17:0] sample,
	input  logic [2:0]         feedback_kind,
	input  ket_pkg::dp_cmd_t   cmd,
	output ket_pkg::dp_sts_t   sts,
	ket_cfg_if.sink            cfg,
	ket_rsp_if.source          rsp
);

	localparam int unsigned IDX_W = (TOPICS > 1) ? $clog2(TOPICS) : 1;
	localparam int unsigned CNT_W = $clog2(TOPICS + 1);

	ket_pkg::entry_t mem_q [TOPICS];
	ket_pkg::entry_t rd_q;
	ket_pkg::rsp_t   rsp_q, rsp_d;

	logic [16:0]      bw_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] idx_q;
	logic [IDX_W-1:0] slot_q;
	logic [1:0]       len_q, tone_q, det_q;
	logic [31:0]      adapt_q;
	logic             rsp_valid_q;

	logic        cmd_q;
	logic [63:0] key_q;
	logic [16:0] x_q;
	logic [2:0]  kind_q;
	logic        seed_q;
	logic [16:0] ema_cur_q;
	logic [31:0] cnt_cur_q;
	logic [33:0] prod_a_q, prod_b_q;

	logic [16:0] x_clamped;
	logic [16:0] weight;
	logic [16:0] inv_weight;
	logic [34:0] acc;
	logic [16:0] ema_new;
	logic [31:0] cnt_new;
	logic [1:0]  len_n, tone_n, det_n;
	logic        chg, fb_ok;
	logic        finish_any;

	assign cfg.ready = 1'b1;

	always_comb begin
		if (sample[17])
			x_clamped = '0;
		else if (sample[16:0] > ket_pkg::ONE_Q16)
			x_clamped = ket_pkg::ONE_Q16;
		else
			x_clamped = sample[16:0];
	end

	always_comb begin
		if (bw_q == '0)
			weight = ket_pkg::DEFAULT_WEIGHT;
		else if (bw_q > ket_pkg::ONE_Q16)
			weight = ket_pkg::ONE_Q16;
		else
			weight = bw_q;
	end
	assign inv_weight = ket_pkg::ONE_Q16 - weight;

	assign acc     = {1'b0, prod_a_q} + {1'b0, prod_b_q};
	assign ema_new = seed_q ? x_q : acc[32:16];
	assign cnt_new = (cnt_cur_q == '1) ? cnt_cur_q : cnt_cur_q + 32'd1;

	always_comb begin
		len_n = len_q;
		tone_n = tone_q;
		det_n = det_q;
		chg = 1'b0;
		fb_ok = 1'b1;
		case (ket_pkg::fb_kind_t'(kind_q))
			ket_pkg::FB_TOO_LONG: begin
				if (len_q != 2'd0) begin
					len_n = len_q - 2'd1;
					chg = 1'b1;
				end
			end
			ket_pkg::FB_TOO_SHORT: begin
				if (len_q < ket_pkg::LEN_MAX) begin
					len_n = len_q + 2'd1;
					chg = 1'b1;
				end
			end
			ket_pkg::FB_TOO_TECHNICAL: begin
				if (det_q != 2'd0) begin
					det_n = det_q - 2'd1;
					chg = 1'b1;
				end
			end
			ket_pkg::FB_TOO_SIMPLE: begin
				if (det_q < ket_pkg::DET_MAX) begin
					det_n = det_q + 2'd1;
					chg = 1'b1;
				end
			end
			ket_pkg::FB_TOO_FORMAL: begin
				if (tone_q != 2'd0) begin
					tone_n = tone_q - 2'd1;
					chg = 1'b1;
				end
			end
			ket_pkg::FB_TOO_DIRECT: begin
				if (tone_q < ket_pkg::TONE_MAX) begin
					tone_n = tone_q + 2'd1;
					chg = 1'b1;
				end
			end
			default: fb_ok = 1'b0;
		endcase
	end

	assign finish_any = cmd.finish_obs || cmd.finish_fb || cmd.finish_rej;

	always_comb begin
		rsp_d = '0;
		rsp_d.length_style = len_q;
		rsp_d.tone_style = tone_q;
		rsp_d.detail_style = det_q;
		rsp_d.adapt_count = adapt_q;
		rsp_d.status = ket_pkg::STS_REJECT;
		rsp_d.level = ket_pkg::LVL_UNKNOWN;
		if (cmd.finish_obs) begin
			rsp_d.status = ket_pkg::STS_OK;
			rsp_d.ema_value = ema_new;
			rsp_d.level = ket_pkg::classify(ema_new);
			rsp_d.sample_count = cnt_new;
			rsp_d.adapt_count = adapt_q + 32'd1;
		end else if (cmd.finish_fb) begin
			rsp_d.status = fb_ok ? ket_pkg::STS_OK : ket_pkg::STS_BAD_FB;
			rsp_d.changed = chg;
			rsp_d.length_style = len_n;
			rsp_d.tone_style = tone_n;
			rsp_d.detail_style = det_n;
			rsp_d.adapt_count = adapt_q + {31'd0, fb_ok};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= ket_pkg::DEFAULT_WEIGHT;
			used_q <= '0;
			idx_q <= '0;
			len_q <= ket_pkg::LEN_NORMAL;
			tone_q <= ket_pkg::TONE_NEUTRAL;
			det_q <= ket_pkg::DET_NEUTRAL;
			adapt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid)
				bw_q <= cfg.blend_weight;
			if (cmd.capture)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd.finish_obs) begin
				used_q <= used_q + CNT_W'(seed_q);
				adapt_q <= adapt_q + 32'd1;
			end
			if (cmd.finish_fb && fb_ok) begin
				len_q <= len_n;
				tone_q <= tone_n;
				det_q <= det_n;
				adapt_q <= adapt_q + 32'd1;
			end
			if (finish_any)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= command;
			key_q <= topic_key;
			x_q <= x_clamped;
			kind_q <= feedback_kind;
		end
		if (cmd.rd)
			rd_q <= mem_q[idx_q[IDX_W-1:0]];
		if (cmd.set_new) begin
			slot_q <= used_q[IDX_W-1:0];
			seed_q <= 1'b1;
			ema_cur_q <= x_q;
			cnt_cur_q <= '0;
		end else if (cmd.set_hit) begin
			slot_q <= idx_q[IDX_W-1:0];
			seed_q <= 1'b0;
			ema_cur_q <= rd_q.ema;
			cnt_cur_q <= rd_q.samples;
		end
		if (cmd.mul) begin
			prod_a_q <= 34'(inv_weight) * 34'(ema_cur_q);
			prod_b_q <= 34'(weight) * 34'(x_q);
		end
		if (cmd.finish_obs)
			mem_q[slot_q] <= '{key: key_q, ema: ema_new, samples: cnt_new};
		if (finish_any)
			rsp_q <= rsp_d;
	end

	assign sts.is_feedback = (cmd_q == ket_pkg::CMD_FEEDBACK);
	assign sts.key_zero    = (key_q == '0);
	assign sts.scan_end    = (idx_q == used_q);
	assign sts.table_full  = (used_q == CNT_W'(TOPICS));
	assign sts.key_hit     = (rd_q.key == key_q);
	assign sts.out_free    = !rsp_valid_q || rsp.ready;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.ema_value    = rsp_q.ema_value;
	assign rsp.level        = rsp_q.level;
	assign rsp.sample_count = rsp_q.sample_count;
	assign rsp.changed      = rsp_q.changed;
	assign rsp.length_style = rsp_q.length_style;
	assign rsp.tone_style   = rsp_q.tone_style;
	assign rsp.detail_style = rsp_q.detail_style;
	assign rsp.adapt_count  = rsp_q.adapt_count;

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TOPICS))
		else $error("topic count beyond table size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		finish_any |-> (!rsp_valid_q || rsp.ready))
		else $error("result word overwritten before it was taken");

	a_new_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish_obs && seed_q) |=> (used_q == CNT_W'($past(used_q) + 1'b1)))
		else $error("new topic did not advance the fill count");

	a_style_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tone_q <= ket_pkg::TONE_MAX) && (det_q <= ket_pkg::DET_MAX))
		else $error("style setting out of range");

endmodule
